[sv/pts_pkg.sv]
package pts_pkg;

	localparam int SlotW = 6;
	localparam int PosW = 20;
	localparam int PixW = 16;
	localparam int LifeW = 11;
	localparam int GapW = 12;
	localparam int MinW = 8;
	localparam int HotW = 12;
	localparam int TimeW = 32;
	localparam int OpacW = 8;
	localparam int NumW = 19;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 12;
	localparam int OpacityFull = 217;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_LIFETIME = 3'd0,
		CFG_GAP = 3'd1,
		CFG_MIN_INTERVAL = 3'd2,
		CFG_HOTSPOT_X = 3'd3,
		CFG_HOTSPOT_Y = 3'd4
	} cfg_idx_t;

	localparam logic OP_MOVE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic alive;
		logic signed [PosW-1:0] x;
		logic signed [PosW-1:0] y;
		logic [TimeW-1:0] born;
	} entry_t;

	// round half away from zero to whole pixels, saturated
	function automatic logic signed [PixW-1:0] to_pix(logic signed [PosW-1:0] p,
			logic [HotW-1:0] h);
		logic signed [PosW:0] d;
		logic [PosW:0] m;
		logic [PixW:0] r;
		logic [PixW:0] rn;
		logic signed [PixW-1:0] res;
		d = {p[PosW-1], p} - {{(PosW+1-HotW){1'b0}}, h};
		m = d[PosW] ? (~d + 1'b1) : d;
		r = (PixW+1)'((m + (PosW+1)'(8)) >> 4);
		rn = (PixW+1)'(0) - r;
		if (!d[PosW]) begin
			res = (r > (PixW+1)'(32767)) ? 16'sh7FFF : r[PixW-1:0];
		end else begin
			res = (r > (PixW+1)'(32768)) ? 16'sh8000 : rn[PixW-1:0];
		end
		return res;
	endfunction

endpackage

[sv/pts_div.sv]
module pts_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [pts_pkg::LifeW-1:0] diff,
	input logic [pts_pkg::LifeW-1:0] den,
	output logic done,
	output logic [pts_pkg::OpacW-1:0] quot
);
	import pts_pkg::*;

	logic busy_q;
	logic done_q;
	logic [2:0] cnt_q;
	logic [NumW-1:0] rem_q;
	logic [NumW-1:0] dsh_q;
	logic [OpacW-1:0] q_q;
	logic ge;

	assign ge = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			rem_q <= '0;
			dsh_q <= '0;
			q_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 3'd7;
				rem_q <= NumW'(diff) * NumW'(OpacityFull);
				dsh_q <= NumW'(den) << 7;
				q_q <= '0;
			end else if (busy_q) begin
				if (ge) begin
					rem_q <= rem_q - dsh_q;
				end
				q_q <= {q_q[OpacW-2:0], ge};
				dsh_q <= dsh_q >> 1;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 3'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = q_q;

endmodule

[sv/pointer_trail_spawner_unit.sv]
// Pointer trail spawner. A move transaction may spawn a copy at the ring head, then every
// transaction but a clearing move sweeps all TRAIL_SLOTS ring entries of one copy memory, one
// entry per cycle while no surviving copy holds the sweep, and emits each surviving copy in
// slot order, waiting on the 8-step opacity divider and on any output stall. A move
// with zero lifetime or a hidden pointer, and reset itself, run a clearing pass over all
// TRAIL_SLOTS entries of the memory; no item is taken during it, configuration writes are.
module pointer_trail_spawner_unit #(
	parameter int TRAIL_SLOTS = 64
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [pts_pkg::CfgIdxW-1:0] cfg_index,
	input logic [pts_pkg::CfgDataW-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic operation,
	input logic signed [pts_pkg::PosW-1:0] pointer_x,
	input logic signed [pts_pkg::PosW-1:0] pointer_y,
	input logic pointer_shown,
	input logic [pts_pkg::TimeW-1:0] now_ms,
	output logic out_valid,
	input logic out_stall,
	output logic [pts_pkg::SlotW-1:0] slot,
	output logic signed [pts_pkg::PixW-1:0] copy_x,
	output logic signed [pts_pkg::PixW-1:0] copy_y,
	output logic [pts_pkg::OpacW-1:0] opacity,
	output logic last
);
	import pts_pkg::*;

	localparam int IdxW = (TRAIL_SLOTS > 1) ? $clog2(TRAIL_SLOTS) : 1;
	localparam logic [IdxW-1:0] LastSlot = IdxW'(TRAIL_SLOTS - 1);

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_CLR = 10'b0000000010,
		ST_CHK1 = 10'b0000000100,
		ST_CHK2 = 10'b0000001000,
		ST_CHK3 = 10'b0000010000,
		ST_SWST = 10'b0000100000,
		ST_SWEEP = 10'b0001000000,
		ST_DIV = 10'b0010000000,
		ST_EMIT = 10'b0100000000,
		ST_FLUSH = 10'b1000000000
	} state_t;

	entry_t mem [TRAIL_SLOTS];
	entry_t rd_q;
	entry_t wdata;
	logic mem_we;
	logic [IdxW-1:0] waddr;
	logic [IdxW-1:0] rd_addr;

	state_t state_q;
	logic [IdxW-1:0] cur_q;
	logic [IdxW-1:0] head_q;
	logic [IdxW-1:0] nxt;
	logic [IdxW-1:0] newest;
	logic [IdxW-1:0] head_nxt;

	logic [LifeW-1:0] life_q;
	logic [GapW-1:0] gap_q;
	logic [MinW-1:0] min_q;
	logic [HotW-1:0] hx_q;
	logic [HotW-1:0] hy_q;

	logic signed [PosW-1:0] px_q;
	logic signed [PosW-1:0] py_q;
	logic [TimeW-1:0] now_q;

	logic signed [PosW:0] dx_q;
	logic signed [PosW:0] dy_q;
	logic alive_q;
	logic age_ok_q;
	logic signed [2*PosW+1:0] sqx_full;
	logic signed [2*PosW+1:0] sqy_full;
	logic [2*PosW:0] sqx_q;
	logic [2*PosW:0] sqy_q;
	logic [2*GapW-1:0] g2_q;
	logic spawn;

	logic [TimeW-1:0] age;
	logic surv;
	logic signed [PosW-1:0] sx_q;
	logic signed [PosW-1:0] sy_q;
	logic [LifeW-1:0] life_left;
	logic div_start;
	logic div_done;
	logic [OpacW-1:0] quot;

	logic pend_valid_q;
	logic [SlotW-1:0] pend_slot_q;
	logic signed [PixW-1:0] pend_x_q;
	logic signed [PixW-1:0] pend_y_q;
	logic [OpacW-1:0] pend_op_q;

	logic out_valid_q;
	logic [SlotW-1:0] out_slot_q;
	logic signed [PixW-1:0] out_x_q;
	logic signed [PixW-1:0] out_y_q;
	logic [OpacW-1:0] out_op_q;
	logic out_last_q;
	logic out_free;
	logic out_load;
	logic accept;

	assign nxt = (cur_q == LastSlot) ? '0 : cur_q + 1'b1;
	assign newest = (head_q == '0) ? LastSlot : head_q - 1'b1;
	assign head_nxt = (head_q == LastSlot) ? '0 : head_q + 1'b1;

	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = pend_valid_q && out_free
		&& ((state_q == ST_EMIT) || (state_q == ST_FLUSH));

	assign age = now_q - rd_q.born;
	assign surv = rd_q.alive && (age < TimeW'(life_q));
	assign life_left = life_q - age[LifeW-1:0];
	assign sqx_full = dx_q * dx_q;
	assign sqy_full = dy_q * dy_q;
	assign spawn = !alive_q
		|| (((2*PosW+2)'(sqx_q) + (2*PosW+2)'(sqy_q) >= (2*PosW+2)'(g2_q)) && age_ok_q);
	assign div_start = (state_q == ST_SWEEP) && surv;

	// memory port selection
	always_comb begin
		mem_we = 1'b0;
		waddr = cur_q;
		wdata = '0;
		rd_addr = nxt;
		unique case (state_q)
			ST_IDLE: begin
				rd_addr = newest;
			end
			ST_CLR: begin
				mem_we = 1'b1;
			end
			ST_CHK3: begin
				mem_we = spawn;
				waddr = head_q;
				wdata = '{alive: 1'b1, x: px_q, y: py_q, born: now_q};
			end
			ST_SWST: begin
				rd_addr = '0;
			end
			ST_SWEEP: begin
				mem_we = rd_q.alive && !surv;
			end
			ST_CHK1, ST_CHK2, ST_DIV, ST_EMIT, ST_FLUSH: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[rd_addr];
	end

	pts_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.diff(life_left),
		.den(life_q),
		.done(div_done),
		.quot(quot)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			life_q <= '0;
			gap_q <= GapW'(96);
			min_q <= MinW'(12);
			hx_q <= '0;
			hy_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_LIFETIME: life_q <= cfg_data[LifeW-1:0];
				CFG_GAP: gap_q <= cfg_data[GapW-1:0];
				CFG_MIN_INTERVAL: min_q <= cfg_data[MinW-1:0];
				CFG_HOTSPOT_X: hx_q <= cfg_data[HotW-1:0];
				CFG_HOTSPOT_Y: hy_q <= cfg_data[HotW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			cur_q <= '0;
			head_q <= '0;
			px_q <= '0;
			py_q <= '0;
			now_q <= '0;
			dx_q <= '0;
			dy_q <= '0;
			alive_q <= 1'b0;
			age_ok_q <= 1'b0;
			sqx_q <= '0;
			sqy_q <= '0;
			g2_q <= '0;
			sx_q <= '0;
			sy_q <= '0;
			pend_valid_q <= 1'b0;
			pend_slot_q <= '0;
			pend_x_q <= '0;
			pend_y_q <= '0;
			pend_op_q <= '0;
			out_valid_q <= 1'b0;
			out_slot_q <= '0;
			out_x_q <= '0;
			out_y_q <= '0;
			out_op_q <= '0;
			out_last_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						px_q <= pointer_x;
						py_q <= pointer_y;
						now_q <= now_ms;
						if (operation == OP_TICK) begin
							state_q <= ST_SWST;
						end else if (life_q == '0 || !pointer_shown) begin
							cur_q <= '0;
							head_q <= '0;
							state_q <= ST_CLR;
						end else begin
							state_q <= ST_CHK1;
						end
					end
				end
				ST_CLR: begin
					cur_q <= nxt;
					if (cur_q == LastSlot) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CHK1: begin
					dx_q <= {px_q[PosW-1], px_q} - {rd_q.x[PosW-1], rd_q.x};
					dy_q <= {py_q[PosW-1], py_q} - {rd_q.y[PosW-1], rd_q.y};
					alive_q <= rd_q.alive;
					age_ok_q <= (now_q - rd_q.born) >= TimeW'(min_q);
					state_q <= ST_CHK2;
				end
				ST_CHK2: begin
					sqx_q <= sqx_full[2*PosW:0];
					sqy_q <= sqy_full[2*PosW:0];
					g2_q <= (2*GapW)'(gap_q) * (2*GapW)'(gap_q);
					state_q <= ST_CHK3;
				end
				ST_CHK3: begin
					if (spawn) begin
						head_q <= head_nxt;
					end
					state_q <= ST_SWST;
				end
				ST_SWST: begin
					cur_q <= '0;
					state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					if (surv) begin
						sx_q <= rd_q.x;
						sy_q <= rd_q.y;
						state_q <= ST_DIV;
					end else if (cur_q == LastSlot) begin
						state_q <= ST_FLUSH;
					end else begin
						cur_q <= nxt;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!pend_valid_q || out_free) begin
						if (pend_valid_q) begin
							out_slot_q <= pend_slot_q;
							out_x_q <= pend_x_q;
							out_y_q <= pend_y_q;
							out_op_q <= pend_op_q;
							out_last_q <= 1'b0;
						end
						pend_valid_q <= 1'b1;
						pend_slot_q <= SlotW'(cur_q);
						pend_x_q <= to_pix(sx_q, hx_q);
						pend_y_q <= to_pix(sy_q, hy_q);
						pend_op_q <= quot;
						if (cur_q == LastSlot) begin
							state_q <= ST_FLUSH;
						end else begin
							cur_q <= nxt;
							state_q <= ST_SWEEP;
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_valid_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_slot_q <= pend_slot_q;
						out_x_q <= pend_x_q;
						out_y_q <= pend_y_q;
						out_op_q <= pend_op_q;
						out_last_q <= 1'b1;
						pend_valid_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign slot = out_slot_q;
	assign copy_x = out_x_q;
	assign copy_y = out_y_q;
	assign opacity = out_op_q;
	assign last = out_last_q;

endmodule
